FILE: sv/ekhb_pkg.sv
// Package for the event kinematic histogram binner: sizes, edge tables, merge table.
// No dependencies.
`default_nettype none
package ekhb_pkg;
  localparam int TransferBins = 24;
  localparam int ClassCount   = 58;
  localparam int CntW         = 32;
  localparam int HistDepth    = TransferBins * TransferBins * ClassCount;
  localparam int AddrW        = $clog2(HistDepth);
  localparam int StepUnits    = 16 * 50;   // one bin in 1/16 MeV

  localparam logic OP_BIN  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // momentum edges in 1/16 MeV
  function automatic logic [20:0] mom_edge(input logic [3:0] i);
    logic [20:0] e;
    unique case (i)
      4'd0: e = 21'd80;      4'd1: e = 21'd4800;   4'd2: e = 21'd6400;
      4'd3: e = 21'd8000;    4'd4: e = 21'd9600;   4'd5: e = 21'd11200;
      4'd6: e = 21'd12800;   4'd7: e = 21'd14400;  4'd8: e = 21'd16000;
      4'd9: e = 21'd20000;   4'd10: e = 21'd24000; 4'd11: e = 21'd32000;
      4'd12: e = 21'd48000;  4'd13: e = 21'd80000; 4'd14: e = 21'd480000;
      default: e = 21'd0;
    endcase
    return e;
  endfunction

  // cosine edges in hundredths
  function automatic logic signed [7:0] cos_edge(input logic [3:0] i);
    logic signed [7:0] e;
    unique case (i)
      4'd0: e = -8'sd100; 4'd1: e = 8'sd20; 4'd2: e = 8'sd60; 4'd3: e = 8'sd70;
      4'd4: e = 8'sd80;   4'd5: e = 8'sd85; 4'd6: e = 8'sd90; 4'd7: e = 8'sd94;
      4'd8: e = 8'sd98;   4'd9: e = 8'sd100;
      default: e = 8'sd0;
    endcase
    return e;
  endfunction

  typedef logic [5:0] merge_row_t [14];
  function automatic logic [5:0] merge(input logic [3:0] k, input logic [3:0] m);
    merge_row_t r;
    unique case (k)
      4'd0: r = '{0,0,0,0,0,0,0,0,0,0,0,0,0,0};
      4'd1: r = '{1,2,3,4,5,5,5,5,5,5,5,5,5,5};
      4'd2: r = '{6,7,8,9,10,10,11,11,11,11,11,11,11,11};
      4'd3: r = '{12,13,14,15,16,16,17,17,17,17,17,17,17,17};
      4'd4: r = '{18,19,20,21,22,22,23,23,24,24,24,24,24,24};
      4'd5: r = '{25,26,27,28,29,29,30,30,31,31,32,32,32,32};
      4'd6: r = '{33,33,34,35,36,36,37,37,37,38,38,39,39,39};
      4'd7: r = '{40,40,41,42,43,43,44,44,45,46,47,48,49,49};
      default: r = '{50,50,50,51,51,52,52,53,53,54,54,55,56,57};
    endcase
    return (m < 4'd14) ? r[m] : 6'd0;
  endfunction
endpackage
`default_nettype wire

FILE: sv/ekhb_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on ekhb_pkg.
`default_nettype none
interface ekhb_in_if (input wire logic clk);
  logic               valid, ready;
  logic               op;
  logic [19:0]        muon_momentum;
  logic signed [15:0] muon_cosine;
  logic signed [20:0] energy_loss;
  logic signed [32:0] q_squared;
  logic               has_pion;
  logic [4:0]         read_energy_bin, read_transfer_bin;
  logic [5:0]         read_class;
  modport source (output valid, op, muon_momentum, muon_cosine, energy_loss,
                  q_squared, has_pion, read_energy_bin, read_transfer_bin,
                  read_class, input ready);
  modport sink (input valid, op, muon_momentum, muon_cosine, energy_loss,
                q_squared, has_pion, read_energy_bin, read_transfer_bin,
                read_class, output ready);
endinterface

interface ekhb_out_if (input wire logic clk);
  logic                       valid, ready;
  logic                       accepted;
  logic [4:0]                 energy_bin, transfer_bin;
  logic [5:0]                 class_bin;
  logic [ekhb_pkg::CntW-1:0]  bin_count, good_event_count;
  modport source (output valid, accepted, energy_bin, transfer_bin, class_bin,
                  bin_count, good_event_count, input ready);
  modport sink (input valid, accepted, energy_bin, transfer_bin, class_bin,
                bin_count, good_event_count, output ready);
endinterface
`default_nettype wire

FILE: sv/event_kinematic_histogram_binner.sv
// Event histogram binner: one word in flight. A bin event passes edge search and merge,
// radicand, square root, divide by 800 by compare against step multiples (one step per
// bin of energy and of transfer), address, memory read and write; a read passes address
// and memory read. The next word can be taken the cycle after the result leaves.
// After rst a clearing pass zeroes all 33408 words of the histogram memory.
// Depends on ekhb_pkg, ekhb_if, ekhb_ram.
`default_nettype none
module event_kinematic_histogram_binner (
  input wire logic clk,
  input wire logic rst,
  ekhb_in_if.sink    in_ch,
  ekhb_out_if.source out_ch
);
  localparam int AW = ekhb_pkg::AddrW;
  localparam int CW = ekhb_pkg::CntW;
  localparam logic [CW-1:0] CMAX = '1;

  typedef enum logic [8:0] {
    S_CLR = 9'b000000001, S_IDLE = 9'b000000010, S_BIN = 9'b000000100,
    S_MUL = 9'b000001000, S_SQRT = 9'b000010000, S_DIV = 9'b000100000,
    S_RD  = 9'b001000000, S_WR   = 9'b010000000, S_OUT = 9'b100000000
  } state_t;
  state_t state;

  // captured word
  logic        op;
  logic [19:0] mom;
  logic signed [15:0] cosv;
  logic signed [20:0] w16;
  logic signed [32:0] q2;
  logic        pion;
  logic [4:0]  eb, tb;
  logic [5:0]  cb;
  logic        ok;
  logic signed [41:0] wsq;
  logic signed [42:0] rad;
  logic [41:0] x, rt, bitm;
  logic [5:0]  iter;
  logic [21:0] rem;
  logic [AW-1:0] addr, clr_addr;
  logic        inrange;
  logic [CW-1:0] total, cnt;
  logic        acc;

  // bin search over edge lists, combinational on captured fields
  logic [3:0] mb, kb;
  logic       mb_ok, kb_ok;
  always_comb begin
    logic signed [23:0] c100;
    logic signed [23:0] lo, hi;
    mb = 4'd0; mb_ok = 1'b0; kb = 4'd0; kb_ok = 1'b0;
    c100 = 24'(cosv) * 24'sd100;
    for (int i = 0; i < 14; i++)
      if ({1'b0, mom} > ekhb_pkg::mom_edge(4'(i)) &&
          {1'b0, mom} <= ekhb_pkg::mom_edge(4'(i + 1))) begin
        mb = 4'(i); mb_ok = 1'b1;
      end
    for (int i = 0; i < 9; i++) begin
      lo = 24'(ekhb_pkg::cos_edge(4'(i))) <<< 14;
      hi = 24'(ekhb_pkg::cos_edge(4'(i + 1))) <<< 14;
      if (c100 > lo && c100 <= hi) begin kb = 4'(i); kb_ok = 1'b1; end
    end
  end

  logic [CW-1:0] rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr;
  ekhb_ram #(.Width(CW), .Depth(ekhb_pkg::HistDepth)) u_hist (
    .clk, .we, .waddr, .wdata, .raddr(addr), .rdata
  );

  // write port: clearing pass, or the saturating increment once read data is in
  always_comb begin
    we = 1'b0; waddr = addr; wdata = '0;
    if (state == S_CLR) begin
      we = 1'b1; waddr = clr_addr;
    end else if (state == S_WR && op == ekhb_pkg::OP_BIN && inrange && iter == 6'd63) begin
      we = 1'b1; wdata = (rdata < CMAX) ? rdata + 1'b1 : rdata;
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.accepted = acc;
  assign out_ch.energy_bin = eb;
  assign out_ch.transfer_bin = tb;
  assign out_ch.class_bin = cb;
  assign out_ch.bin_count = cnt;
  assign out_ch.good_event_count = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_addr <= '0; total <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(ekhb_pkg::HistDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          op <= in_ch.op; mom <= in_ch.muon_momentum; cosv <= in_ch.muon_cosine;
          w16 <= in_ch.energy_loss; q2 <= in_ch.q_squared;
          pion <= in_ch.has_pion; eb <= in_ch.read_energy_bin;
          tb <= in_ch.read_transfer_bin; cb <= in_ch.read_class;
          state <= (in_ch.op == ekhb_pkg::OP_READ) ? S_RD : S_BIN;
        end
        S_BIN: begin
          ok <= !pion && mb_ok && kb_ok && !w16[20];
          cb <= ekhb_pkg::merge(kb, mb);
          wsq <= w16 * w16;
          state <= S_MUL;
        end
        S_MUL: begin
          rad <= 43'(wsq) - (43'(q2) <<< 8);
          state <= S_SQRT;
          // square root seed
          bitm <= 42'd1 << 40; rt <= '0; iter <= 6'd21;
        end
        S_SQRT: begin
          if (iter == 6'd21) begin
            x <= rad[41:0];
            if (rad[42]) ok <= 1'b0;
            iter <= iter - 1'b1;
          end else if (bitm != 0) begin
            if (x >= rt + bitm) begin
              x <= x - (rt + bitm); rt <= (rt >> 1) + bitm;
            end else rt <= rt >> 1;
            bitm <= bitm >> 2;
          end else begin
            // w div 800: w < 2^20 gives e < 1311
            eb <= '0; tb <= '0; rem <= rt[21:0]; iter <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // compare against step multiples: first pass energy, then transfer; saturate past range
          if (iter == 6'd0) begin
            if ({1'b0, w16[19:0]} >= 21'(ekhb_pkg::StepUnits) * 21'(eb + 1'b1)
                && eb != 5'(ekhb_pkg::TransferBins)) eb <= eb + 1'b1;
            else iter <= 6'd1;
          end else begin
            if (rem >= 22'(ekhb_pkg::StepUnits) * 22'(tb + 1'b1)
                && tb != 5'(ekhb_pkg::TransferBins))
              tb <= tb + 1'b1;
            else begin
              if (eb >= 5'(ekhb_pkg::TransferBins) || tb >= 5'(ekhb_pkg::TransferBins))
                ok <= 1'b0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          inrange <= eb < 5'(ekhb_pkg::TransferBins) && tb < 5'(ekhb_pkg::TransferBins)
                     && cb < 6'(ekhb_pkg::ClassCount) && (op == ekhb_pkg::OP_READ || ok);
          addr <= AW'((32'(eb) * ekhb_pkg::TransferBins + 32'(tb))
                      * ekhb_pkg::ClassCount + 32'(cb));
          state <= S_WR;
        end
        S_WR: if (iter != 6'd63) begin
          iter <= 6'd63;   // wait out the registered read
        end else begin
          if (op == ekhb_pkg::OP_READ) begin
            acc <= 1'b0; cnt <= inrange ? rdata : '0;
          end else if (inrange) begin
            acc <= 1'b1; cnt <= wdata;
            if (total < CMAX) total <= total + 1'b1;
          end else begin
            acc <= 1'b0; cnt <= '0; eb <= '0; tb <= '0; cb <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_CLR;
      endcase
      if (state == S_RD) iter <= '0;
    end
  end
endmodule
`default_nettype wire

FILE: sv/ekhb_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module ekhb_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/ekhb_checker.sv
// Port-level checker for the histogram binner, bound to the top level.
// Depends on ekhb_pkg and ekhb_if.
`default_nettype none
module ekhb_checker (
  input wire logic clk, rst,
  input wire logic in_valid, in_ready, out_valid, out_ready, out_accepted,
  input wire logic [ekhb_pkg::CntW-1:0] out_total,
  input wire logic [4:0] out_eb
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_tot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> $stable(out_total))
    else $error("total moved without word");
  a_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_accepted |-> out_eb < 5'(ekhb_pkg::TransferBins))
    else $error("bin out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
endmodule

bind event_kinematic_histogram_binner ekhb_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_accepted(out_ch.accepted), .out_total(out_ch.good_event_count),
  .out_eb(out_ch.energy_bin)
);
`default_nettype wire
